// ===== hdl/cffis_pkg.sv =====
// Package for the CAN frame filter and id statistics block: sizes, constants, helpers.
package cffis_pkg;

  localparam int RING_DEPTH_DEF  = 24;
  localparam int TABLE_DEPTH_DEF = 48;

  localparam int ID_W    = 29;
  localparam int KEY_W   = 30;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int SLOT_W  = 6;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_IMPORTANT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_EXTENDED    = 1'd1;

  localparam logic [ID_W-1:0]  ID_EXT_ALL_ONES = 29'h1FFF_FFFF;
  localparam logic [ID_W-1:0]  ID_SPECIAL      = 29'h30C;
  localparam logic [LEN_W-1:0] MAX_LEN         = 4'd8;
  localparam logic [LEN_W-1:0] SPECIAL_LEN     = 4'd2;
  localparam logic [7:0]       BYTE_ONES       = 8'hFF;

  localparam logic [ID_W-1:0] WL_ID0 = 29'h301;
  localparam logic [ID_W-1:0] WL_ID1 = 29'h302;
  localparam logic [ID_W-1:0] WL_ID2 = 29'h303;
  localparam logic [ID_W-1:0] WL_ID3 = 29'h30C;
  localparam logic [ID_W-1:0] WL_ID4 = 29'h447;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] last_time;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] bytes;
  } tbl_ent_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] bytes;
  } ring_ent_t;

  function automatic logic on_whitelist(input logic [ID_W-1:0] id);
    return (id == WL_ID0) || (id == WL_ID1) || (id == WL_ID2) ||
           (id == WL_ID3) || (id == WL_ID4);
  endfunction

  // keeps bytes below len (len at most 8)
  function automatic logic [DATA_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (LEN_W'(b) < len) m[b*8 +: 8] = BYTE_ONES;
    end
    return m;
  endfunction

endpackage

// ===== hdl/can_frame_filter_and_id_stats_top.sv =====
// CAN frame filter with recent-frame ring and per-id statistics table.
// A dropped frame goes through S_DROP to the output register; a kept frame passes S_SCAN and S_WB.
// One frame at a time: in_stall holds new frames until the current one is done, and the
//   slot-by-slot scan over the one read port of the statistics memory sets the pace.
// A finished result waits in the output register while the next frame is taken.
// Reset (rst_n, sync): valid bits, counters, pointers and config cleared at once;
//   no clearing pass, memory contents are gated by the per-slot valid bits.
module can_frame_filter_and_id_stats_top
  import cffis_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ID_W-1:0]       in_can_id,
  input  logic                  in_is_extended,
  input  logic [LEN_W-1:0]      in_data_length,
  input  logic [DATA_W-1:0]     in_payload,
  input  logic [TIME_W-1:0]     in_now_ms,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_dropped,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [CNT_W-1:0]      out_hit_count,
  output logic                  out_new_entry,
  output logic                  out_evicted,
  output logic [CNT_W-1:0]      out_drop_total
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_W = $clog2(TABLE_DEPTH + 1);
  localparam int RP_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RF_W   = $clog2(RING_DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(TABLE_DEPTH);
  localparam logic [RP_W-1:0]   RING_LAST = RP_W'(RING_DEPTH - 1);
  localparam logic [RF_W-1:0]   RING_FULL = RF_W'(RING_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WB, S_DROP} state_t;

  state_t state_r;

  // configuration
  logic filter_imp_r, drop_ext_r;

  // captured frame
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] now_r;
  logic [LEN_W-1:0]  len_r;
  logic [DATA_W-1:0] bytes_r;

  // scan bookkeeping
  logic [SCAN_W-1:0] scan_cnt_r;
  logic              chk_vld_r;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              found_r, have_free_r, old_have_r;
  logic [IDX_W-1:0]  hit_idx_r, free_idx_r, old_idx_r;
  logic [CNT_W-1:0]  hit_cnt_r;
  logic [TIME_W-1:0] old_time_r;
  logic              found_nxt, have_free_nxt, old_have_nxt;
  logic [IDX_W-1:0]  hit_idx_nxt, free_idx_nxt, old_idx_nxt;
  logic [CNT_W-1:0]  hit_cnt_nxt;
  logic [TIME_W-1:0] old_time_nxt;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0]       drop_cnt_r;

  // ring
  logic [RP_W-1:0] ring_ptr_r;
  logic [RF_W-1:0] ring_fill_r;

  // output register
  logic              out_valid_r, out_dropped_r, out_new_r, out_evict_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]  out_cnt_r, out_drop_tot_r;

  // memories
  tbl_ent_t  tbl_mem [TABLE_DEPTH];
  tbl_ent_t  rd_q_r;
  ring_ent_t ring_mem [RING_DEPTH];

  // ---------------------------------------------------------------- filter
  logic              in_acc;
  logic [DATA_W-1:0] in_mask;
  logic              ext_all_ones, short_special, drop_c;

  assign in_acc  = in_valid && !in_stall;
  assign in_mask = len_mask(in_data_length);

  always_comb begin
    ext_all_ones = in_is_extended && (in_can_id == ID_EXT_ALL_ONES) &&
                   (in_data_length != '0) && ((in_payload & in_mask) == in_mask);
    short_special = !in_is_extended && (in_can_id == ID_SPECIAL) &&
                    (in_data_length == SPECIAL_LEN) &&
                    (in_payload[15:0] == {BYTE_ONES, BYTE_ONES});
    drop_c = (in_data_length > MAX_LEN) ||
             (filter_imp_r && drop_ext_r && in_is_extended) ||
             (filter_imp_r && !in_is_extended && !on_whitelist(in_can_id)) ||
             ext_all_ones || short_special;
  end

  // ---------------------------------------------------------------- scan check
  logic       rd_en, ent_vld;
  logic [IDX_W-1:0] rd_addr;

  assign rd_en   = (state_r == S_SCAN) && (scan_cnt_r < SCAN_END);
  assign rd_addr = scan_cnt_r[IDX_W-1:0];
  assign ent_vld = valid_r[chk_idx_r];

  always_comb begin
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    have_free_nxt = have_free_r;
    free_idx_nxt  = free_idx_r;
    old_have_nxt  = old_have_r;
    old_idx_nxt   = old_idx_r;
    old_time_nxt  = old_time_r;
    if (in_acc) begin
      // fresh scan for the new frame
      found_nxt     = 1'b0;
      have_free_nxt = 1'b0;
      old_have_nxt  = 1'b0;
      hit_idx_nxt   = '0;
      free_idx_nxt  = '0;
      old_idx_nxt   = '0;
    end else if (chk_vld_r && !found_r) begin
      if (ent_vld && (rd_q_r.key == key_r)) begin
        found_nxt   = 1'b1;
        hit_idx_nxt = chk_idx_r;
        hit_cnt_nxt = rd_q_r.count;
      end else if (ent_vld) begin
        // oldest entry, lowest index on ties
        if (!old_have_r || (rd_q_r.last_time < old_time_r)) begin
          old_have_nxt = 1'b1;
          old_idx_nxt  = chk_idx_r;
          old_time_nxt = rd_q_r.last_time;
        end
      end else if (!have_free_r) begin
        have_free_nxt = 1'b1;
        free_idx_nxt  = chk_idx_r;
      end
    end
  end

  // ---------------------------------------------------------------- write back
  logic             out_free, wb_go, drop_go;
  logic [IDX_W-1:0] wb_idx;
  logic [CNT_W-1:0] wb_cnt;
  tbl_ent_t         wb_ent;

  assign out_free = !out_valid_r || !out_stall;
  assign wb_go    = (state_r == S_WB) && out_free;
  assign drop_go  = (state_r == S_DROP) && out_free;

  always_comb begin
    priority if (found_r)     wb_idx = hit_idx_r;
    else if (have_free_r)     wb_idx = free_idx_r;
    else                      wb_idx = old_idx_r;
    wb_cnt           = found_r ? (hit_cnt_r + CNT_W'(1)) : CNT_W'(1);
    wb_ent.key       = key_r;
    wb_ent.count     = wb_cnt;
    wb_ent.last_time = now_r;
    wb_ent.len       = len_r;
    wb_ent.bytes     = bytes_r;
  end

  always_ff @(posedge clk) begin
    if (wb_go) tbl_mem[wb_idx] <= wb_ent;
    if (rd_en) rd_q_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && !drop_c) begin
      ring_mem[ring_ptr_r] <= '{stamp: in_now_ms,
                               key:   {in_is_extended, in_can_id},
                               len:   in_data_length,
                               bytes: in_payload & in_mask};
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      filter_imp_r <= 1'b0;
      drop_ext_r   <= 1'b0;
      scan_cnt_r   <= '0;
      chk_vld_r    <= 1'b0;
      valid_r      <= '0;
      drop_cnt_r   <= '0;
      ring_ptr_r   <= '0;
      ring_fill_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_FILTER_IMPORTANT: filter_imp_r <= cfg_wdata[0];
          REG_DROP_EXTENDED:    drop_ext_r   <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (wb_go || drop_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      chk_vld_r <= rd_en;
      chk_idx_r <= rd_addr;

      found_r     <= found_nxt;
      hit_idx_r   <= hit_idx_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      have_free_r <= have_free_nxt;
      free_idx_r  <= free_idx_nxt;
      old_have_r  <= old_have_nxt;
      old_idx_r   <= old_idx_nxt;
      old_time_r  <= old_time_nxt;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            key_r       <= {in_is_extended, in_can_id};
            now_r       <= in_now_ms;
            len_r       <= in_data_length;
            bytes_r     <= in_payload & in_mask;
            scan_cnt_r  <= '0;
            if (drop_c) begin
              state_r <= S_DROP;
            end else begin
              state_r    <= S_SCAN;
              ring_ptr_r <= (ring_ptr_r == RING_LAST) ? '0 : ring_ptr_r + RP_W'(1);
              if (ring_fill_r != RING_FULL) ring_fill_r <= ring_fill_r + RF_W'(1);
            end
          end
        end
        S_SCAN: begin
          if (rd_en) scan_cnt_r <= scan_cnt_r + SCAN_W'(1);
          if (chk_vld_r && (chk_idx_r == LAST_IDX)) state_r <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            valid_r[wb_idx] <= 1'b1;
            out_dropped_r   <= 1'b0;
            out_slot_r      <= SLOT_W'(wb_idx);
            out_cnt_r       <= wb_cnt;
            out_new_r       <= !found_r;
            out_evict_r     <= !found_r && !have_free_r;
            out_drop_tot_r  <= drop_cnt_r;
            state_r         <= S_IDLE;
          end
        end
        S_DROP: begin
          if (drop_go) begin
            drop_cnt_r     <= drop_cnt_r + CNT_W'(1);
            out_dropped_r  <= 1'b1;
            out_slot_r     <= '0;
            out_cnt_r      <= '0;
            out_new_r      <= 1'b0;
            out_evict_r    <= 1'b0;
            out_drop_tot_r <= drop_cnt_r + CNT_W'(1);
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_dropped    = out_dropped_r;
  assign out_slot       = out_slot_r;
  assign out_hit_count  = out_cnt_r;
  assign out_new_entry  = out_new_r;
  assign out_evicted    = out_evict_r;
  assign out_drop_total = out_drop_tot_r;

  // ---------------------------------------------------------------- assertions
  a_evict_is_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> out_new_entry)
    else $error("eviction reported without allocation");

  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (out_hit_count == '0 && !out_new_entry && !out_evicted))
    else $error("dropped beat carries table fields");

  a_wb_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wb_go |=> valid_r[$past(wb_idx)])
    else $error("written slot not marked valid");

  a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_go && !found_r && !have_free_r) |-> (&valid_r))
    else $error("eviction while a free slot exists");

endmodule

// ===== tb/sv/can_frame_filter_and_id_stats_top_tb.sv =====
// Testbench for the CAN frame filter and id statistics block: stimulus, prediction, checks.
module can_frame_filter_and_id_stats_top_tb;
  import cffis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_SIZE   = 64;
  localparam int RAND_FRAMES = 1120;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [ID_W-1:0]   can_id;
    logic              is_extended;
    logic [LEN_W-1:0]  data_length;
    logic [DATA_W-1:0] payload;
    logic [TIME_W-1:0] now_ms;
  } can_frame_t;

  typedef struct packed {
    logic              dropped;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  hit_count;
    logic              new_entry;
    logic              evicted;
    logic [CNT_W-1:0]  drop_total;
  } stat_update_t;

  // Tracks the filter decision and the id table, queues the update each frame should produce.
  class id_stats_tracker;
    bit                filter_on;
    bit                drop_ext;
    bit                slot_used  [TABLE_DEPTH_DEF];
    logic [KEY_W-1:0]  slot_key   [TABLE_DEPTH_DEF];
    logic [CNT_W-1:0]  slot_count [TABLE_DEPTH_DEF];
    logic [TIME_W-1:0] slot_time  [TABLE_DEPTH_DEF];
    logic [CNT_W-1:0]  drops = '0;
    stat_update_t      expected_updates[$];
    int mismatches;
    int updates_seen;
    int dropped_frames;
    int new_slots;
    int evictions;
    int repeat_hits;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic val);
      case (idx)
        REG_FILTER_IMPORTANT: filter_on = val;
        REG_DROP_EXTENDED:    drop_ext  = val;
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] keep_mask(logic [LEN_W-1:0] len);
      if (len >= MAX_LEN) return '1;
      return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function bit rejects(can_frame_t f);
      logic [DATA_W-1:0] m;
      m = keep_mask(f.data_length);
      if (f.data_length > MAX_LEN) return 1'b1;
      if (filter_on && drop_ext && f.is_extended) return 1'b1;
      if (filter_on && !f.is_extended &&
          f.can_id != WL_ID0 && f.can_id != WL_ID1 && f.can_id != WL_ID2 &&
          f.can_id != WL_ID3 && f.can_id != WL_ID4) return 1'b1;
      if (f.is_extended && f.can_id == ID_EXT_ALL_ONES && f.data_length != '0 &&
          (f.payload & m) == m) return 1'b1;
      if (!f.is_extended && f.can_id == ID_SPECIAL && f.data_length == SPECIAL_LEN &&
          f.payload[15:0] == {BYTE_ONES, BYTE_ONES}) return 1'b1;
      return 1'b0;
    endfunction

    function void note_frame(can_frame_t f);
      stat_update_t     upd;
      logic [KEY_W-1:0] key;
      int               idx;
      int               free_idx;
      int               oldest;
      bit               hit;
      upd = '0;
      if (rejects(f)) begin
        drops++;
        dropped_frames++;
        upd.dropped = 1'b1;
      end else begin
        key      = {f.is_extended, f.can_id};
        hit      = 1'b0;
        idx      = 0;
        free_idx = -1;
        oldest   = 0;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
          if (slot_used[i] && slot_key[i] == key) begin
            hit = 1'b1;
            idx = i;
            break;
          end
          if (!slot_used[i] && free_idx < 0) free_idx = i;
          // strict compare keeps the lowest index on equal times
          if (slot_used[i] && slot_time[i] < slot_time[oldest]) oldest = i;
        end
        if (hit) begin
          slot_count[idx]++;
          repeat_hits++;
        end else begin
          idx = (free_idx >= 0) ? free_idx : oldest;
          slot_count[idx] = 1;
          upd.new_entry   = 1'b1;
          upd.evicted     = (free_idx < 0);
          new_slots++;
          if (free_idx < 0) evictions++;
        end
        slot_used[idx] = 1'b1;
        slot_key[idx]  = key;
        slot_time[idx] = f.now_ms;
        upd.slot       = SLOT_W'(idx);
        upd.hit_count  = slot_count[idx];
      end
      upd.drop_total = drops;
      expected_updates.push_back(upd);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_update(stat_update_t got);
      stat_update_t want;
      if (expected_updates.size() == 0) begin
        $error("result beat with no frame pending");
        mismatches++;
        return;
      end
      want = expected_updates.pop_front();
      updates_seen++;
      compare_field("dropped", want.dropped, got.dropped);
      compare_field("slot", want.slot, got.slot);
      compare_field("hit_count", want.hit_count, got.hit_count);
      compare_field("new_entry", want.new_entry, got.new_entry);
      compare_field("evicted", want.evicted, got.evicted);
      compare_field("drop_total", want.drop_total, got.drop_total);
    endfunction

    function int pending();
      return expected_updates.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [ID_W-1:0]       in_can_id;
  logic                  in_is_extended;
  logic [LEN_W-1:0]      in_data_length;
  logic [DATA_W-1:0]     in_payload;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_dropped;
  logic [SLOT_W-1:0]     out_slot;
  logic [CNT_W-1:0]      out_hit_count;
  logic                  out_new_entry;
  logic                  out_evicted;
  logic [CNT_W-1:0]      out_drop_total;

  id_stats_tracker   tracker = new;
  bit                steady;
  bit                hold_request;
  int                frames_sent;
  logic [TIME_W-1:0] clock_ms;
  logic [ID_W-1:0]   pool_id  [POOL_SIZE];
  bit                pool_ext [POOL_SIZE];

  can_frame_filter_and_id_stats_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_can_id      (in_can_id),
    .in_is_extended (in_is_extended),
    .in_data_length (in_data_length),
    .in_payload     (in_payload),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dropped    (out_dropped),
    .out_slot       (out_slot),
    .out_hit_count  (out_hit_count),
    .out_new_entry  (out_new_entry),
    .out_evicted    (out_evicted),
    .out_drop_total (out_drop_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 30);
    return $urandom_range(40, 150);
  endfunction

  function automatic can_frame_t mk_frame(logic [ID_W-1:0] id, logic ext,
                                          logic [LEN_W-1:0] len, logic [DATA_W-1:0] data,
                                          logic [TIME_W-1:0] ms);
    can_frame_t f;
    f.can_id      = id;
    f.is_extended = ext;
    f.data_length = len;
    f.payload     = data;
    f.now_ms      = ms;
    return f;
  endfunction

  function automatic can_frame_t random_frame();
    can_frame_t f;
    int         r;
    int         k;
    int         b;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, POOL_SIZE - 1);
    f.payload     = {$urandom, $urandom};
    f.data_length = LEN_W'($urandom_range(0, 8));
    f.can_id      = pool_id[k];
    f.is_extended = pool_ext[k];
    clock_ms      = clock_ms + $urandom_range(0, 2);
    f.now_ms      = ($urandom_range(0, 99) < 6) ? TIME_W'($urandom) : clock_ms;
    if (tracker.filter_on && r < 45) begin
      f.is_extended = 1'b0;
      case ($urandom_range(0, 4))
        0: f.can_id = WL_ID0;
        1: f.can_id = WL_ID1;
        2: f.can_id = WL_ID2;
        3: f.can_id = WL_ID3;
        default: f.can_id = WL_ID4;
      endcase
    end else if (r < 75) begin
      // pool key as drawn above
    end else if (r < 82) begin
      f.data_length = LEN_W'($urandom_range(9, 15));
    end else if (r < 88) begin
      f.can_id      = ID_EXT_ALL_ONES;
      f.is_extended = 1'b1;
      f.data_length = LEN_W'($urandom_range(0, 8));
      f.payload     = f.payload | tracker.keep_mask(f.data_length);
      if (f.data_length != '0 && $urandom_range(0, 1) == 1) begin
        b = $urandom_range(0, f.data_length - 1);
        f.payload[8*b +: 8] = 8'($urandom_range(0, 254));
      end
    end else if (r < 93) begin
      f.can_id      = ID_SPECIAL;
      f.is_extended = ($urandom_range(0, 5) == 0);
      f.data_length = LEN_W'($urandom_range(1, 3));
      f.payload[15:0] = 16'hFFFF;
      if ($urandom_range(0, 1) == 1) f.payload[8*$urandom_range(0, 1) +: 8] = 8'h7F;
    end else begin
      f.can_id      = ID_W'($urandom);
      f.is_extended = 1'($urandom_range(0, 1));
      f.data_length = LEN_W'($urandom_range(0, 15));
    end
    return f;
  endfunction

  task automatic send_frame(input can_frame_t f, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_can_id      <= f.can_id;
    in_is_extended <= f.is_extended;
    in_data_length <= f.data_length;
    in_payload     <= f.payload;
    in_now_ms      <= f.now_ms;
    do @(posedge clk); while (in_stall);
    tracker.note_frame(f);
    frames_sent++;
  endtask

  // only while nothing is in flight
  task automatic apply_setting(input logic filt, input logic dext);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FILTER_IMPORTANT;
    cfg_wdata <= filt;
    @(posedge clk);
    cfg_index <= REG_DROP_EXTENDED;
    cfg_wdata <= dext;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_reg(REG_FILTER_IMPORTANT, filt);
    tracker.set_reg(REG_DROP_EXTENDED, dext);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result side: checks accepted beats, random stalls, one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        tracker.check_update({out_dropped, out_slot, out_hit_count, out_new_entry,
                              out_evicted, out_drop_total});
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 80);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #(25ms);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int waited;
    int gap;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_can_id      = '0;
    in_is_extended = 1'b0;
    in_data_length = '0;
    in_payload     = '0;
    in_now_ms      = '0;
    steady         = 1'b0;
    hold_request   = 1'b0;
    frames_sent    = 0;
    clock_ms       = 32'd1000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no filtering: length limit and the two all-ones patterns
    apply_setting(1'b0, 1'b0);
    send_frame(mk_frame('0, 1'b0, 4'd0, '0, '0), pick_gap());
    send_frame(mk_frame(29'h7FF, 1'b0, 4'd8, '1, 32'd1), pick_gap());
    send_frame(mk_frame(ID_EXT_ALL_ONES, 1'b1, 4'd8, '1, 32'd2), pick_gap());
    send_frame(mk_frame(ID_EXT_ALL_ONES, 1'b1, 4'd1, 64'hFF, 32'd3), pick_gap());
    send_frame(mk_frame(ID_EXT_ALL_ONES, 1'b1, 4'd3, 64'hFFFF_FFFF_FF7F_FFFF, 32'd4),
               pick_gap());
    send_frame(mk_frame(ID_EXT_ALL_ONES, 1'b1, 4'd0, '1, 32'd5), pick_gap());
    send_frame(mk_frame(ID_EXT_ALL_ONES, 1'b0, 4'd8, '1, 32'd6), pick_gap());
    send_frame(mk_frame(ID_SPECIAL, 1'b0, 4'd2, 64'hFFFF, 32'd7), pick_gap());
    send_frame(mk_frame(ID_SPECIAL, 1'b0, 4'd2, 64'hFF7F, 32'd8), pick_gap());
    send_frame(mk_frame(ID_SPECIAL, 1'b0, 4'd3, 64'hFFFFFF, 32'd9), pick_gap());
    send_frame(mk_frame(ID_SPECIAL, 1'b1, 4'd2, 64'hFFFF, 32'd10), pick_gap());
    send_frame(mk_frame(29'h123, 1'b0, 4'd9, '1, 32'd11), pick_gap());
    send_frame(mk_frame('0, 1'b0, 4'd15, '0, 32'd12), pick_gap());
    send_frame(mk_frame('0, 1'b0, 4'd4, 64'h0123_4567_89AB_CDEF, '1), pick_gap());
    send_frame(mk_frame('0, 1'b1, 4'd5, 64'hFEDC_BA98_7654_3210, 32'd13), pick_gap());
    wait_drained();

    // whitelist only, extended still allowed
    apply_setting(1'b1, 1'b0);
    send_frame(mk_frame(WL_ID0, 1'b0, 4'd8, '1, 32'd20), pick_gap());
    send_frame(mk_frame(WL_ID1, 1'b0, 4'd1, 64'h5A, 32'd21), pick_gap());
    send_frame(mk_frame(WL_ID2, 1'b0, 4'd2, 64'hA5A5, 32'd22), pick_gap());
    send_frame(mk_frame(WL_ID4, 1'b0, 4'd0, '0, 32'd23), pick_gap());
    send_frame(mk_frame(ID_SPECIAL, 1'b0, 4'd2, 64'hFFFF, 32'd24), pick_gap());
    send_frame(mk_frame(29'h123, 1'b0, 4'd2, 64'h1, 32'd25), pick_gap());
    send_frame(mk_frame(29'h1000_0301, 1'b0, 4'd2, 64'h1, 32'd26), pick_gap());
    send_frame(mk_frame(WL_ID0, 1'b1, 4'd3, 64'h77, 32'd27), pick_gap());
    wait_drained();

    // whitelist only, extended dropped
    apply_setting(1'b1, 1'b1);
    send_frame(mk_frame(WL_ID0, 1'b1, 4'd3, 64'h77, 32'd30), pick_gap());
    send_frame(mk_frame(WL_ID4, 1'b0, 4'd8, 64'h1122_3344_5566_7788, 32'd31), pick_gap());
    wait_drained();

    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_ext[k] = ($urandom_range(0, 2) == 0);
      pool_id[k]  = (pool_ext[k] || $urandom_range(0, 3) == 0) ? ID_W'($urandom)
                                                               : ID_W'($urandom_range(0, 2047));
    end

    apply_setting(1'b0, 1'b0);
    for (int n = 0; n < RAND_FRAMES; n++) begin
      case (n)
        280: begin wait_drained(); apply_setting(1'b1, 1'b0); end
        560: begin wait_drained(); apply_setting(1'b1, 1'b1); end
        840: begin wait_drained(); apply_setting(1'b0, 1'b1); end
        default: ;
      endcase
      if (n == 150) wait_drained();   // sender waits out every pending beat
      steady = (n >= 420 && n < 500);
      if (n == 700) hold_request = 1'b1;
      gap = (n >= 700 && n < 712) ? 0 : pick_gap();
      send_frame(random_frame(), gap);
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    waited = 0;
    while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TABLE_DEPTH_DEF + 8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d expected results never arrived", tracker.pending());
      tracker.mismatches++;
    end

    $display("Run: %0d frames over four filter settings, %0d result beats checked.",
             frames_sent, tracker.updates_seen);
    $display("Mix: %0d dropped, %0d slot allocations (%0d evictions), %0d repeat hits.",
             tracker.dropped_frames, tracker.new_slots, tracker.evictions,
             tracker.repeat_hits);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cffis_pkg.sv
hdl/can_frame_filter_and_id_stats_top.sv
tb/sv/can_frame_filter_and_id_stats_top_tb.sv
